### hw/rtl/cascaded_biquad_bandpass_defines.svh
// assertion macros for the band-pass filter checker
`ifndef CASCADED_BIQUAD_BANDPASS_DEFINES_SVH
`define CASCADED_BIQUAD_BANDPASS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbb check failed: same-cycle rule");

// next-cycle implication, disabled during reset
`define CBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbb check failed: next-cycle rule");

`endif

### hw/rtl/cbb_pkg.sv
// types, constants, microcode program and rounding for the band-pass filter
`timescale 1ns / 1ps
`default_nettype none
package cbb_pkg;

  // sizes
  localparam int CHANNELS       = 2;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_BITS      = 27;
  localparam int REG_COUNT      = 8;
  localparam int REG_IDX_BITS   = 3;
  localparam int CH_BITS        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAPS           = 2;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int RND_BITS       = ACC_BITS - COEF_FRAC_BITS + 1;
  localparam int STEP_BITS      = 4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef coef_t [REG_COUNT-1:0]         coef_bank_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [REG_IDX_BITS-1:0]       reg_idx_t;
  typedef logic [CH_BITS-1:0]            ch_idx_t;
  typedef logic [STEP_BITS-1:0]          step_t;

  // coefficient register map
  typedef enum logic [REG_IDX_BITS-1:0] {
    C_LOW_B0  = 3'd0,
    C_LOW_B1  = 3'd1,
    C_LOW_A1  = 3'd2,
    C_LOW_A2  = 3'd3,
    C_HIGH_B0 = 3'd4,
    C_HIGH_B1 = 3'd5,
    C_HIGH_A1 = 3'd6,
    C_HIGH_A2 = 3'd7
  } coef_sel_e;

  localparam coef_t COEF_RESET [REG_COUNT] = '{
    27'sd16777216,  27'sd33554432,  27'sd33554432,  27'sd16777216,
    27'sd16777216, -27'sd33554432, -27'sd33554432,  27'sd16777216
  };

  // multiplier operand select
  typedef enum logic [2:0] {
    OP_X   = 3'd0,
    OP_X1  = 3'd1,
    OP_X2  = 3'd2,
    OP_M1  = 3'd3,
    OP_M2  = 3'd4,
    OP_MID = 3'd5,
    OP_Y1  = 3'd6,
    OP_Y2  = 3'd7
  } opnd_e;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    RND_NONE = 2'd0,
    RND_MID  = 2'd1,
    RND_OUT  = 2'd2
  } rnd_e;

  // sequencing: fall through, hold for a new sample, hold for a free output
  typedef enum logic [1:0] {
    JC_NEXT     = 2'd0,
    JC_WAIT_IN  = 2'd1,
    JC_WAIT_OUT = 2'd2
  } jc_e;

  typedef struct packed {
    coef_sel_e coef;
    opnd_e     opnd;
    acc_op_e   acc;
    rnd_e      rnd;
    jc_e       jc;
    step_t     target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    coef_sel_e coef;
    opnd_e     opnd;
    acc_op_e   acc;
    logic      load;
    logic      rnd_mid;
    logic      commit;
  } cbb_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic out_busy;
  } cbb_stat_t;

  localparam step_t STEP_IDLE = 4'd0;

  function automatic ucode_t uw(input coef_sel_e c, input opnd_e o, input acc_op_e a,
                                input rnd_e r, input jc_e j, input step_t t);
    ucode_t w;
    w.coef   = c;
    w.opnd   = o;
    w.acc    = a;
    w.rnd    = r;
    w.jc     = j;
    w.target = t;
    return w;
  endfunction

  // control program: low-pass sum, overlapped high-pass sum, round and commit
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      4'd0:    w = uw(C_LOW_B0,  OP_X,   ACC_NONE, RND_NONE, JC_WAIT_IN,  STEP_IDLE);
      4'd1:    w = uw(C_LOW_B0,  OP_X,   ACC_LOAD, RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd2:    w = uw(C_LOW_B1,  OP_X1,  ACC_ADD,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd3:    w = uw(C_LOW_B0,  OP_X2,  ACC_ADD,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd4:    w = uw(C_LOW_A1,  OP_M1,  ACC_SUB,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd5:    w = uw(C_LOW_A2,  OP_M2,  ACC_SUB,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd6:    w = uw(C_HIGH_B1, OP_M1,  ACC_LOAD, RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd7:    w = uw(C_HIGH_B0, OP_M2,  ACC_ADD,  RND_MID,  JC_NEXT,     STEP_IDLE);
      4'd8:    w = uw(C_HIGH_A1, OP_Y1,  ACC_SUB,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd9:    w = uw(C_HIGH_A2, OP_Y2,  ACC_SUB,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd10:   w = uw(C_HIGH_B0, OP_MID, ACC_ADD,  RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd11:   w = uw(C_HIGH_B0, OP_MID, ACC_NONE, RND_NONE, JC_NEXT,     STEP_IDLE);
      4'd12:   w = uw(C_HIGH_B0, OP_MID, ACC_NONE, RND_OUT,  JC_WAIT_OUT, STEP_IDLE);
      default: w = uw(C_LOW_B0,  OP_X,   ACC_NONE, RND_NONE, JC_WAIT_OUT, STEP_IDLE);
    endcase
    return w;
  endfunction

  localparam logic signed [ACC_BITS:0] RND_HALF =
    (ACC_BITS + 1)'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_BITS-1:0] RES_MAX =
    RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_BITS-1:0] RES_MIN =
    RND_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // round half up, drop the fraction, clamp to the sample range
  function automatic sample_t round_sat(input acc_t acc);
    logic signed [ACC_BITS:0]   t;
    logic signed [RND_BITS-1:0] r;
    sample_t                    s;
    t = (ACC_BITS + 1)'(acc) + RND_HALF;
    r = RND_BITS'(t >>> COEF_FRAC_BITS);
    if (r > RES_MAX) begin
      s = SAMPLE_BITS'(RES_MAX);
    end else if (r < RES_MIN) begin
      s = SAMPLE_BITS'(RES_MIN);
    end else begin
      s = r[SAMPLE_BITS-1:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/cbb_if.sv
// valid/ready stream interfaces for samples in and filtered samples out
`timescale 1ns / 1ps
`default_nettype none
interface cbb_in_if;
  import cbb_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    channel;
  logic    block_end;

  modport source (output valid, output sample_in, output channel, output block_end,
                  input ready);
  modport sink (input valid, input sample_in, input channel, input block_end,
                output ready);
endinterface

interface cbb_out_if;
  import cbb_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    channel_out;
  logic    block_end_out;

  modport source (output valid, output sample_out, output channel_out,
                  output block_end_out, input ready);
  modport sink (input valid, input sample_out, input channel_out, input block_end_out,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/cbb_coef_regs.sv
// coefficient register file written from the configuration port
`timescale 1ns / 1ps
`default_nettype none
module cbb_coef_regs (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire cbb_pkg::reg_idx_t   cfg_index,
  input  wire cbb_pkg::coef_t      cfg_data,
  output cbb_pkg::coef_bank_t      coefs
);
  import cbb_pkg::*;

  coef_bank_t coef_r;

  // register writes, reset to the default coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        coef_r[i] <= COEF_RESET[i];
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  assign coefs = coef_r;

endmodule
`default_nettype wire

### hw/rtl/cbb_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps
`default_nettype none
module cbb_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cbb_pkg::cbb_stat_t stat,
  output cbb_pkg::cbb_ctl_t      ctl
);
  import cbb_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t uc;
  logic   load;

  assign uc       = ucode_rom(step_r);
  assign in_ready = rst_n && (uc.jc == JC_WAIT_IN);
  assign load     = in_ready && in_valid;

  // control word to the datapath
  always_comb begin
    ctl.coef    = uc.coef;
    ctl.opnd    = uc.opnd;
    ctl.acc     = uc.acc;
    ctl.load    = load;
    ctl.rnd_mid = (uc.rnd == RND_MID);
    ctl.commit  = (uc.rnd == RND_OUT) && !stat.out_busy;
  end

  // next step
  always_comb begin
    case (uc.jc)
      JC_NEXT:     step_nxt = step_t'(step_r + 1'b1);
      JC_WAIT_IN:  step_nxt = load ? step_t'(step_r + 1'b1) : step_r;
      JC_WAIT_OUT: step_nxt = stat.out_busy ? step_r : uc.target;
      default:     step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cbb_dp.sv
// datapath: operand capture, shared multiply-accumulate, rounding, history
`timescale 1ns / 1ps
`default_nettype none
module cbb_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cbb_pkg::sample_t     sample_in,
  input  wire logic                 channel,
  input  wire logic                 block_end,
  input  wire cbb_pkg::coef_bank_t  coefs,
  input  wire cbb_pkg::cbb_ctl_t    ctl,
  output cbb_pkg::cbb_stat_t        stat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cbb_pkg::sample_t          sample_out,
  output logic                      channel_out,
  output logic                      block_end_out
);
  import cbb_pkg::*;

  // per-channel history, newest tap first
  sample_t in_hist_r  [CHANNELS][TAPS];
  sample_t mid_hist_r [CHANNELS][TAPS];
  sample_t out_hist_r [CHANNELS][TAPS];

  // working copy of the current item
  sample_t x_r, x1_r, x2_r, m1_r, m2_r, y1_r, y2_r, mid_r;
  ch_idx_t ch_idx_r;
  ch_idx_t ch_idx_nxt;
  logic    chbit_r;
  logic    blk_r;

  // multiply-accumulate pipe
  sample_t opnd;
  coef_t   coef;
  prod_t   prod_r;
  acc_op_e acc_op_r;
  acc_t    acc_r;
  sample_t y_nxt;

  // output register
  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_ch_r;
  logic    out_blk_r;

  assign ch_idx_nxt = (CHANNELS > 1) ? CH_BITS'(channel) : '0;
  assign y_nxt      = round_sat(acc_r);

  // capture sample and its channel history on a transfer in
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r      <= sample_in;
      x1_r     <= in_hist_r[ch_idx_nxt][0];
      x2_r     <= in_hist_r[ch_idx_nxt][1];
      m1_r     <= mid_hist_r[ch_idx_nxt][0];
      m2_r     <= mid_hist_r[ch_idx_nxt][1];
      y1_r     <= out_hist_r[ch_idx_nxt][0];
      y2_r     <= out_hist_r[ch_idx_nxt][1];
      ch_idx_r <= ch_idx_nxt;
      chbit_r  <= channel;
      blk_r    <= block_end;
    end
    if (ctl.rnd_mid) begin
      mid_r <= y_nxt;
    end
  end

  // operand select
  always_comb begin
    case (ctl.opnd)
      OP_X:    opnd = x_r;
      OP_X1:   opnd = x1_r;
      OP_X2:   opnd = x2_r;
      OP_M1:   opnd = m1_r;
      OP_M2:   opnd = m2_r;
      OP_MID:  opnd = mid_r;
      OP_Y1:   opnd = y1_r;
      OP_Y2:   opnd = y2_r;
      default: opnd = x_r;
    endcase
  end

  assign coef = coefs[ctl.coef];

  // product register, operands widened to the full product width
  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(coef) * PROD_BITS'(opnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_r <= ACC_NONE;
    end else begin
      acc_op_r <= ctl.acc;
    end
  end

  // accumulator, fed from the product register with the operation delayed to match
  always_ff @(posedge clk) begin
    case (acc_op_r)
      ACC_LOAD: acc_r <= ACC_BITS'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_BITS'(prod_r);
      ACC_SUB:  acc_r <= acc_r - ACC_BITS'(prod_r);
      default:  acc_r <= acc_r;
    endcase
  end

  // history write-back when the result is committed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int t = 0; t < TAPS; t++) begin
          in_hist_r[c][t]  <= '0;
          mid_hist_r[c][t] <= '0;
          out_hist_r[c][t] <= '0;
        end
      end
    end else if (ctl.commit) begin
      in_hist_r[ch_idx_r][0]  <= x_r;
      in_hist_r[ch_idx_r][1]  <= x1_r;
      mid_hist_r[ch_idx_r][0] <= mid_r;
      mid_hist_r[ch_idx_r][1] <= m1_r;
      out_hist_r[ch_idx_r][0] <= y_nxt;
      out_hist_r[ch_idx_r][1] <= y1_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_sample_r <= y_nxt;
      out_ch_r     <= chbit_r;
      out_blk_r    <= blk_r;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign sample_out    = out_sample_r;
  assign channel_out   = out_ch_r;
  assign block_end_out = out_blk_r;

endmodule
`default_nettype wire

### hw/rtl/cascaded_biquad_bandpass.sv
// top level: two-stage band-pass filter (low-pass then high-pass biquad)
//
// in_ch carries one signed sample with its channel bit and a block-end
// marker; out_ch returns the filtered sample with both echoed. A transfer
// happens on a clock edge with valid and ready high.
// cfg_we writes cfg_data into coefficient register cfg_index (low b0, b1,
// a1, a2, then high b0, b1, a1, a2); write only while no sample is in work.
// out_ch.valid is registered and rises once the last step commits the
// rounded result. Samples go in one at a time, only at the idle step. The
// ten products of both stages run one per cycle through a single 27x24
// multiplier and accumulator, stepped by the microcode program.
// Reset (synchronous, rst_n low) restores the default coefficients, clears
// all channel history and drops out_ch.valid.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and processed, and waits at its final step until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module cascaded_biquad_bandpass (
  input  wire logic               clk,
  input  wire logic               rst_n,
  cbb_in_if.sink                  in_ch,
  cbb_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire cbb_pkg::reg_idx_t  cfg_index,
  input  wire cbb_pkg::coef_t     cfg_data
);
  import cbb_pkg::*;

  coef_bank_t coefs;
  cbb_ctl_t   ctl;
  cbb_stat_t  stat;

  cbb_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  cbb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  cbb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_in     (in_ch.sample_in),
    .channel       (in_ch.channel),
    .block_end     (in_ch.block_end),
    .coefs         (coefs),
    .ctl           (ctl),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .sample_out    (out_ch.sample_out),
    .channel_out   (out_ch.channel_out),
    .block_end_out (out_ch.block_end_out)
  );

endmodule
`default_nettype wire

### hw/rtl/cbb_checker.sv
// port-level checker for the band-pass filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "cascaded_biquad_bandpass_defines.svh"
module cbb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // samples taken but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = 2'(pend_r + 2'd1);
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = 2'(pend_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `CBB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CBB_ASSERT_IMP(a_no_phantom, clk, rst_n, out_xfer, pend_r != 2'd0)
  `CBB_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_xfer, !in_ready)
  `CBB_ASSERT_IMP(a_two_in_flight_max, clk, rst_n, pend_r == 2'd2, !in_ready)

endmodule

bind cascaded_biquad_bandpass cbb_checker u_cbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
`default_nettype wire

### tb/cascaded_biquad_bandpass_test.sv
// self-checking testbench for the cascaded biquad band-pass filter
`timescale 1ns / 1ps
module cascaded_biquad_bandpass_test;
  import cbb_pkg::*;

  typedef struct packed {
    sample_t level;
    logic    chan;
    logic    block_end;
  } audio_item_t;

  localparam longint LEVEL_MAX   = 64'sd8388607;
  localparam longint LEVEL_MIN   = -64'sd8388608;
  localparam int     IDLE_PCT    = 28;
  localparam int     DRAIN_WAIT  = 16;

  localparam coef_t DEFAULT_COEFS [REG_COUNT] = '{
    27'sd16777216,  27'sd33554432,  27'sd33554432,  27'sd16777216,
    27'sd16777216, -27'sd33554432, -27'sd33554432,  27'sd16777216
  };
  // stable low-pass near 0.05 fs followed by high-pass near 0.01 fs
  localparam coef_t BAND_COEFS [REG_COUNT] = '{
    27'sd337222,    27'sd674444,   -27'sd26189234,  27'sd10760906,
    27'sd16047407, -27'sd32094814, -27'sd32064616,  27'sd15351153
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  coef_sel_e cfg_index;
  coef_t     cfg_data;

  cbb_in_if  sample_ch ();
  cbb_out_if result_ch ();

  cascaded_biquad_bandpass u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter state as the block should hold it
  coef_t   coefs     [REG_COUNT];
  sample_t raw_hist  [CHANNELS][TAPS] = '{default: '0};
  sample_t low_hist  [CHANNELS][TAPS] = '{default: '0};
  sample_t band_hist [CHANNELS][TAPS] = '{default: '0};

  audio_item_t pending_samples [$];
  audio_item_t expected_results [$];
  bit          sample_taken = 1'b0;
  bit          steady_flow = 1'b0;
  int unsigned hold_off = 0;
  int unsigned mismatch_count = 0;

  // one direct-form-I section: exact sum, round half up, saturate
  function automatic sample_t biquad_stage(input sample_t x, input sample_t x1,
                                           input sample_t x2, input sample_t y1,
                                           input sample_t y2, input coef_t b0,
                                           input coef_t b1, input coef_t a1,
                                           input coef_t a2);
    longint acc;
    longint r;
    acc = longint'(b0) * longint'(x) + longint'(b1) * longint'(x1)
        + longint'(b0) * longint'(x2) - longint'(a1) * longint'(y1)
        - longint'(a2) * longint'(y2);
    r = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (r > LEVEL_MAX) begin
      r = LEVEL_MAX;
    end else if (r < LEVEL_MIN) begin
      r = LEVEL_MIN;
    end
    return sample_t'(r);
  endfunction

  // low-pass then high-pass on one channel, history updated afterwards
  function automatic audio_item_t filter_sample(input audio_item_t it);
    int          ch;
    sample_t     mid;
    sample_t     y;
    audio_item_t res;
    ch = int'(it.chan) % CHANNELS;
    mid = biquad_stage(it.level, raw_hist[ch][0], raw_hist[ch][1],
                       low_hist[ch][0], low_hist[ch][1], coefs[C_LOW_B0],
                       coefs[C_LOW_B1], coefs[C_LOW_A1], coefs[C_LOW_A2]);
    y = biquad_stage(mid, low_hist[ch][0], low_hist[ch][1],
                     band_hist[ch][0], band_hist[ch][1], coefs[C_HIGH_B0],
                     coefs[C_HIGH_B1], coefs[C_HIGH_A1], coefs[C_HIGH_A2]);
    raw_hist[ch][1]  = raw_hist[ch][0];
    raw_hist[ch][0]  = it.level;
    low_hist[ch][1]  = low_hist[ch][0];
    low_hist[ch][0]  = mid;
    band_hist[ch][1] = band_hist[ch][0];
    band_hist[ch][0] = y;
    res.level     = y;
    res.chan      = it.chan;
    res.block_end = it.block_end;
    return res;
  endfunction

  function automatic sample_t random_level();
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      3, 4, 5: return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t random_coef();
    case ($urandom_range(3))
      0: return coef_t'($urandom);
      1: return coef_t'(int'($urandom_range(33554432)) - 16777216);
      2: return coef_t'(int'($urandom_range(2097152)) - 1048576);
      default: return coef_t'(int'($urandom_range(67108864)) - 33554432);
    endcase
  endfunction

  task automatic queue_sample(input sample_t level, input logic chan, input logic block_end);
    audio_item_t it;
    it.level     = level;
    it.chan      = chan;
    it.block_end = block_end;
    pending_samples.push_back(it);
  endtask

  task automatic queue_random_samples(input int count);
    repeat (count) begin
      queue_sample(random_level(), 1'($urandom), $urandom_range(7) == 0);
    end
  endtask

  // coefficient writes, only while the filter is idle
  task automatic load_coefs(input coef_t bank [REG_COUNT]);
    for (int i = 0; i < REG_COUNT; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= coef_sel_e'(i);
      cfg_data  <= bank[i];
      coefs[i] = bank[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued sample went in and every result came out
  task automatic drain();
    while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic stall_results(input int unsigned cycles);
    @(posedge clk);
    hold_off = cycles;
  endtask

  // sample source: holds the offer until transfer, random gaps otherwise
  always @(negedge clk) begin : drive_samples
    audio_item_t it;
    if (!rst_n) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_taken) begin
      sample_taken = 1'b0;
      if (pending_samples.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
        it = pending_samples.pop_front();
        sample_ch.sample_in <= it.level;
        sample_ch.channel   <= it.chan;
        sample_ch.block_end <= it.block_end;
        sample_ch.valid     <= 1'b1;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: random back-pressure plus long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // check result transfers, then predict from input transfers
  always @(posedge clk) begin : check_results
    audio_item_t want;
    audio_item_t taken;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: sample_out %0d channel_out %0d block_end_out %0d",
               result_ch.sample_out, result_ch.channel_out, result_ch.block_end_out);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.sample_out !== want.level) begin
          $error("sample_out mismatch: expected %0d, got %0d", want.level,
                 result_ch.sample_out);
          mismatch_count++;
        end
        if (result_ch.channel_out !== want.chan) begin
          $error("channel_out mismatch: expected %0d, got %0d", want.chan,
                 result_ch.channel_out);
          mismatch_count++;
        end
        if (result_ch.block_end_out !== want.block_end) begin
          $error("block_end_out mismatch: expected %0d, got %0d", want.block_end,
                 result_ch.block_end_out);
          mismatch_count++;
        end
      end
    end
    if (rst_n && sample_ch.valid && sample_ch.ready) begin
      taken.level     = sample_ch.sample_in;
      taken.chan      = sample_ch.channel;
      taken.block_end = sample_ch.block_end;
      expected_results.push_back(filter_sample(taken));
      sample_taken = 1'b1;
    end
  end

  initial begin : stimulus
    coef_t   bank [REG_COUNT];
    sample_t corner_levels [11];
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = C_LOW_B0;
    cfg_data              = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.sample_in   = '0;
    sample_ch.channel     = 1'b0;
    sample_ch.block_end   = 1'b0;
    result_ch.ready       = 1'b0;
    coefs                 = DEFAULT_COEFS;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners on default coefficients: full-scale, zero and alternating-bit levels on both channels
    corner_levels = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                      24'sh800000, 24'sh000000, 24'sh000001, 24'shFFFFFF, 24'sh555555,
                      24'shAAAAAA};
    for (int i = 0; i < 11; i++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        queue_sample(corner_levels[i], 1'(ch), i == 10);
      end
    end
    drain();

    // long receiver hold-off while samples keep coming
    stall_results(300);
    queue_random_samples(100);
    drain();

    // realistic band-pass, first with no gaps on either side
    load_coefs(BAND_COEFS);
    steady_flow = 1'b1;
    queue_random_samples(150);
    drain();
    steady_flow = 1'b0;
    queue_random_samples(200);
    drain();

    // coefficient extremes
    foreach (bank[i]) bank[i] = 27'sh3FFFFFF;
    load_coefs(bank);
    queue_random_samples(60);
    drain();
    foreach (bank[i]) bank[i] = 27'sh4000000;
    load_coefs(bank);
    queue_random_samples(60);
    drain();
    foreach (bank[i]) bank[i] = (i % 2 == 0) ? 27'sh3FFFFFF : 27'sh4000000;
    load_coefs(bank);
    queue_random_samples(60);
    drain();

    // random coefficient sets
    repeat (6) begin
      foreach (bank[i]) bank[i] = random_coef();
      load_coefs(bank);
      queue_random_samples(80);
      drain();
    end

    // all-zero coefficients give zero results and flush the filtered history to zero
    foreach (bank[i]) bank[i] = '0;
    load_coefs(bank);
    queue_random_samples(20);
    drain();

    // back to the band-pass with another long hold-off
    load_coefs(BAND_COEFS);
    stall_results(400);
    queue_random_samples(150);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cbb_pkg.sv
hw/rtl/cbb_if.sv
hw/rtl/cbb_coef_regs.sv
hw/rtl/cbb_seq.sv
hw/rtl/cbb_dp.sv
hw/rtl/cascaded_biquad_bandpass.sv
hw/rtl/cbb_checker.sv
tb/cascaded_biquad_bandpass_test.sv
